/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

/* hdl/pmst_pkg.sv */
// ---------------------------------------------------------------------------
// pmst_pkg
// Shared constants and types of the minimum spanning tree unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmst_pkg;

   localparam int MAX_VERTS = 32;
   localparam int MAX_EDGES = 256;
   localparam int VIDX_W = $clog2(MAX_VERTS);
   localparam int CNT_W = $clog2(MAX_VERTS + 1);
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ETOT_W = $clog2(MAX_EDGES + 1);
   localparam int CMP_W = CNT_W + 6;
   localparam int KEY_W = 17;
   localparam int EDGE_W = 26;
   localparam logic signed [KEY_W-1:0] KEY_INF = 17'sd32768;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_RUN = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
      logic [VIDX_W-1:0]       idx;
   } cand_type;

   typedef struct packed {
      logic                    clear;
      logic [VIDX_W-1:0]       root;
      logic                    mark;
      logic [VIDX_W-1:0]       mark_idx;
      logic                    upd;
      logic [VIDX_W-1:0]       upd_tgt;
      logic signed [KEY_W-1:0] upd_cost;
      logic [VIDX_W-1:0]       upd_src;
      logic [CNT_W-1:0]        n;
   } ctl_type;

endpackage

`default_nettype wire

/* hdl/pmst_ram.sv */
// ---------------------------------------------------------------------------
// pmst_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/pmst_cell.sv */
// ---------------------------------------------------------------------------
// pmst_cell
// One vertex cell: holds key, known mark and parent, and passes the best
// candidate seen so far along the chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmst_cell
   import pmst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [VIDX_W-1:0] cell_index,
   input  wire ctl_type           ctl,
   input  wire cand_type          cand_in,
   output cand_type               cand_out,
   output logic signed [KEY_W-1:0] key,
   output logic                   known,
   output logic [VIDX_W-1:0]      parent
);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    known_ff, known_in;
   logic [VIDX_W-1:0]       parent_ff, parent_in;
   cand_type                cand_ff, cand_nxt_in;
   logic                    own_ok;

   always_comb begin
      key_in = key_ff;
      known_in = known_ff;
      parent_in = parent_ff;
      if (ctl.clear) begin
         key_in = KEY_INF;
         known_in = (cell_index == ctl.root);
         parent_in = (cell_index == ctl.root) ? ctl.root : '0;
      end else begin
         if (ctl.mark && cell_index == ctl.mark_idx) begin
            known_in = 1'b1;
         end
         if (ctl.upd && cell_index == ctl.upd_tgt && !known_ff && ctl.upd_cost < key_ff) begin
            key_in = ctl.upd_cost;
            parent_in = ctl.upd_src;
         end
      end
   end

   assign own_ok = !known_ff && (key_ff < KEY_INF) && (CMP_W'(cell_index) < CMP_W'(ctl.n));

   always_comb begin
      cand_nxt_in = cand_in;
      if (own_ok && (!cand_in.valid || key_ff < cand_in.key)) begin
         cand_nxt_in.valid = 1'b1;
         cand_nxt_in.key = key_ff;
         cand_nxt_in.idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_INF;
         known_ff <= 1'b0;
         parent_ff <= '0;
         cand_ff <= '0;
      end else begin
         key_ff <= key_in;
         known_ff <= known_in;
         parent_ff <= parent_in;
         cand_ff <= cand_nxt_in;
      end
   end

   assign cand_out = cand_ff;
   assign key = key_ff;
   assign known = known_ff;
   assign parent = parent_ff;

endmodule

`default_nettype wire

/* hdl/prim_min_spanning_tree_unit.sv */
// ---------------------------------------------------------------------------
// prim_min_spanning_tree_unit
// Edge store plus a chain of vertex cells computing a Prim spanning tree.
// ---------------------------------------------------------------------------
// Add-edge and clear requests are handled without leaving the idle state. A run
// request walks the tree one vertex at a time: for the root and for each vertex
// added it scans the whole edge store (one RAM read per cycle) and then lets the
// candidate ripple through the vertex cell chain, then emits one result per
// vertex at one per cycle while the receiver is ready. A bad root gives its
// single result.
`timescale 1ns / 1ps
`default_nettype none

module prim_min_spanning_tree_unit
   import pmst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // from_vertex[4:0], to_vertex[9:5], weight[25:10], root[30:26]
   input  wire logic [31:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // vertex[4:0], parent[9:5], reached[10], link_weight[26:11], edge_overflow[27]
   output logic [31:0]      rsp_tdata,
   // bad_root[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   typedef enum logic [1:0] {ST_IDLE, ST_RELAX, ST_SCAN, ST_EMIT} state_type;

   localparam int SCAN_W = $clog2(MAX_VERTS + 2);

   state_type          state_ff;
   logic [5:0]         vc_ff;
   logic [ETOT_W-1:0]  total_ff;
   logic               ovf_ff;
   logic [ETOT_W-1:0]  e_ff;
   logic               rd_valid_ff;
   logic [VIDX_W-1:0]  pick_ff;
   logic [VIDX_W-1:0]  root_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [SCAN_W-1:0]  scan_ff;
   logic [CNT_W-1:0]   emit_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_user_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic [4:0]         in_from, in_to, in_root;
   logic [15:0]        in_weight;
   logic [CNT_W-1:0]   n_now;
   logic               root_ok;
   logic               wr_en;
   logic [EDGE_W-1:0]  rd_data;
   logic [4:0]         rd_src, rd_tgt;
   logic [15:0]        rd_cost;
   logic               scan_done;
   logic               out_free;
   logic               emit_last;
   logic [VIDX_W-1:0]  emit_idx;
   ctl_type            ctl;
   cand_type           chain [MAX_VERTS+1];
   logic signed [KEY_W-1:0] cell_key [MAX_VERTS];
   logic               cell_known [MAX_VERTS];
   logic [VIDX_W-1:0]  cell_parent [MAX_VERTS];
   logic               em_reached;
   logic [4:0]         em_parent;
   logic [15:0]        em_link;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req_tvalid && req_tready;
   assign in_from = req_tdata[4:0];
   assign in_to = req_tdata[9:5];
   assign in_weight = req_tdata[25:10];
   assign in_root = req_tdata[30:26];
   assign n_now = (CMP_W'(vc_ff) > CMP_W'(MAX_VERTS)) ? CNT_W'(MAX_VERTS) : CNT_W'(vc_ff);
   assign root_ok = CMP_W'(in_root) < CMP_W'(n_now);
   assign wr_en = accept && req_tuser == KIND_ADD && CMP_W'(total_ff) < CMP_W'(MAX_EDGES);

   pmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .AW(EW)) u_edges (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[EW-1:0]),
      .wr_data ({in_from, in_to, in_weight}),
      .rd_addr (e_ff[EW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_src = rd_data[25:21];
   assign rd_tgt = rd_data[20:16];
   assign rd_cost = rd_data[15:0];
   assign scan_done = (state_ff == ST_SCAN) && (CMP_W'(scan_ff) == CMP_W'(MAX_VERTS + 1));

   always_comb begin
      ctl.clear = accept && req_tuser == KIND_RUN && root_ok;
      ctl.root = VIDX_W'(in_root);
      ctl.mark = scan_done && chain[MAX_VERTS].valid;
      ctl.mark_idx = chain[MAX_VERTS].idx;
      ctl.upd = rd_valid_ff && CMP_W'(rd_src) == CMP_W'(pick_ff)
                && CMP_W'(rd_tgt) < CMP_W'(n_ff);
      ctl.upd_tgt = VIDX_W'(rd_tgt);
      ctl.upd_cost = KEY_W'(signed'(rd_cost));
      ctl.upd_src = pick_ff;
      ctl.n = n_ff;
   end

   assign chain[0] = '0;

   for (genvar g = 0; g < MAX_VERTS; g++) begin : g_cell
      pmst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (VIDX_W'(g)),
         .ctl        (ctl),
         .cand_in    (chain[g]),
         .cand_out   (chain[g+1]),
         .key        (cell_key[g]),
         .known      (cell_known[g]),
         .parent     (cell_parent[g])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit_idx = emit_ff[VIDX_W-1:0];
   assign emit_last = CNT_W'(emit_ff + 1'b1) == n_ff;
   assign em_reached = cell_known[emit_idx];
   assign em_parent = em_reached ? 5'(cell_parent[emit_idx]) : 5'd0;
   assign em_link = (em_reached && emit_idx != root_ff) ? cell_key[emit_idx][15:0] : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vc_ff <= 6'd32;
         total_ff <= '0;
         ovf_ff <= 1'b0;
         e_ff <= '0;
         rd_valid_ff <= 1'b0;
         pick_ff <= '0;
         root_ff <= '0;
         n_ff <= '0;
         scan_ff <= '0;
         emit_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
         rsp_user_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vc_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_tuser)
                     KIND_ADD: begin
                        if (wr_en) begin
                           total_ff <= ETOT_W'(total_ff + 1'b1);
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                     end
                     KIND_CLEAR: begin
                        total_ff <= '0;
                        ovf_ff <= 1'b0;
                     end
                     KIND_RUN: begin
                        if (root_ok) begin
                           n_ff <= n_now;
                           root_ff <= VIDX_W'(in_root);
                           pick_ff <= VIDX_W'(in_root);
                           e_ff <= '0;
                           state_ff <= ST_RELAX;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_data_ff <= {4'd0, ovf_ff, 16'd0, 1'b0, 5'd0, in_root};
                           rsp_user_ff <= 1'b1;
                           rsp_last_ff <= 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RELAX: begin
               if (e_ff < total_ff) begin
                  rd_valid_ff <= 1'b1;
                  e_ff <= ETOT_W'(e_ff + 1'b1);
               end else begin
                  scan_ff <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  if (chain[MAX_VERTS].valid) begin
                     pick_ff <= chain[MAX_VERTS].idx;
                     e_ff <= '0;
                     state_ff <= ST_RELAX;
                  end else begin
                     emit_ff <= '0;
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  scan_ff <= SCAN_W'(scan_ff + 1'b1);
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {4'd0, ovf_ff, em_link, em_reached, em_parent,
                                  5'(emit_idx)};
                  rsp_user_ff <= 1'b0;
                  rsp_last_ff <= emit_last;
                  emit_ff <= CNT_W'(emit_ff + 1'b1);
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

`default_nettype wire

/* hdl/pmst_checker.sv */
// ---------------------------------------------------------------------------
// pmst_checker
// Port-level checks of the minimum spanning tree unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pmst_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        csr_wr_en,
   input wire logic [5:0]  csr_wr_data,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped")
   `ASSERT_CLK(a_ready_empty, req_tready |-> !rsp_tvalid, "request taken with response pending")
   `ASSERT_CLK(a_bad_last, (rsp_tvalid && rsp_tuser) |-> rsp_tlast, "bad root result not last")
   `ASSERT_CLK(a_bad_unreached, (rsp_tvalid && rsp_tuser) |-> !rsp_tdata[10],
               "bad root result marked reached")

endmodule

bind prim_min_spanning_tree_unit pmst_checker u_pmst_checker (.*);

`default_nettype wire

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the spanning tree unit: loads edge sets, runs tree
// builds from many roots and vertex counts, and checks every result against
// an internal Prim predictor across several handshake idling phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import pmst_pkg::*;

   localparam logic [1:0] KIND_SKIP = 2'd3;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12000;

   typedef struct packed {
      logic [4:0]         vertex;
      logic [4:0]         parent;
      logic               reached;
      logic signed [15:0] link_weight;
      logic               edge_overflow;
      logic               bad_root;
      logic               last;
   } tree_row_type;

   typedef struct {
      logic [1:0]         kind;
      logic [4:0]         src;
      logic [4:0]         dst;
      logic signed [15:0] weight;
      logic [4:0]         root;
      logic               typed;
      tree_row_type       row;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   // shadow of the block
   logic [4:0]         edge_from [MAX_EDGES];
   logic [4:0]         edge_to [MAX_EDGES];
   logic signed [16:0] edge_wt [MAX_EDGES];
   int                 edge_cnt;
   logic               ovf_flag;
   int                 vcount;

   tree_row_type tree_rows_pending[$];
   tree_row_type typed_rows[$];
   logic      typed_flags[$];
   int        mismatches;
   int        idle_cycles;
   int        send_idle_pct;
   int        recv_stall_pct;

   always #4 clock = ~clock;

   prim_min_spanning_tree_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic predict_tree(input logic [1:0] kind, input logic [4:0] src,
                               input logic [4:0] dst, input logic signed [15:0] wt,
                               input logic [4:0] root);
      logic signed [16:0] key [MAX_VERTS];
      logic               known [MAX_VERTS];
      logic [4:0]         par [MAX_VERTS];
      int                 n, pick, v;
      logic signed [16:0] least;
      tree_row_type       r;
      if (kind == KIND_ADD) begin
         if (edge_cnt >= MAX_EDGES) begin
            ovf_flag = 1'b1;
         end else begin
            edge_from[edge_cnt] = src;
            edge_to[edge_cnt] = dst;
            edge_wt[edge_cnt] = wt;
            edge_cnt++;
         end
      end else if (kind == KIND_CLEAR) begin
         edge_cnt = 0;
         ovf_flag = 1'b0;
      end else if (kind == KIND_RUN) begin
         n = (vcount > MAX_VERTS) ? MAX_VERTS : vcount;
         if (root >= n) begin
            r = '{root, 5'd0, 1'b0, 16'sd0, ovf_flag, 1'b1, 1'b1};
            tree_rows_pending.push_back(r);
         end else begin
            for (int i = 0; i < MAX_VERTS; i++) begin
               key[i] = KEY_INF;
               known[i] = 1'b0;
               par[i] = '0;
            end
            par[root] = root;
            known[root] = 1'b1;
            v = root;
            while (v < n) begin
               for (int e = 0; e < edge_cnt; e++) begin
                  if (edge_from[e] == v && edge_to[e] < n && !known[edge_to[e]]
                      && key[edge_to[e]] > edge_wt[e]) begin
                     key[edge_to[e]] = edge_wt[e];
                     par[edge_to[e]] = v[4:0];
                  end
               end
               pick = n;
               least = KEY_INF;
               for (int i = 0; i < n; i++) begin
                  if (!known[i] && key[i] < least) begin
                     least = key[i];
                     pick = i;
                  end
               end
               if (pick < n) known[pick] = 1'b1;
               v = pick;
            end
            for (int i = 0; i < n; i++) begin
               r.vertex = i[4:0];
               r.parent = known[i] ? par[i] : 5'd0;
               r.reached = known[i];
               r.link_weight = (known[i] && i != root) ? key[i][15:0] : 16'sd0;
               r.edge_overflow = ovf_flag;
               r.bad_root = 1'b0;
               r.last = (i + 1 == n);
               tree_rows_pending.push_back(r);
            end
         end
      end
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [4:0] src,
                               input logic [4:0] dst, input logic signed [15:0] wt,
                               input logic [4:0] root);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, root, wt, dst, src};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tree(kind, src, dst, wt, root);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tree_rows_pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_vertex_count(input int value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[5:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vcount = value;
   endtask

   task automatic random_graph(input int edges, input int span);
      send_request(KIND_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(9) == 0)
            send_request(KIND_ADD, 5'($urandom), 5'($urandom), 16'($urandom),
                         5'($urandom));
         else
            send_request(KIND_ADD, 5'($urandom_range(span - 1)),
                         5'($urandom_range(span - 1)),
                         ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(40)),
                         5'($urandom));
      end
   endtask

   // result checking
   always @(posedge clock) begin
      tree_row_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[4:0], rsp_tdata[9:5], rsp_tdata[10], rsp_tdata[26:11],
                 rsp_tdata[27], rsp_tuser, rsp_tlast};
         if (tree_rows_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = tree_rows_pending.pop_front();
            if (typed_flags.size() != 0 && typed_flags[0]) begin
               if (typed_rows[0] != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("table row %p disagrees with predictor %p",
                              typed_rows[0], want);
               end
            end
            if (typed_flags.size() != 0) begin
               void'(typed_flags.pop_front());
               void'(typed_rows.pop_front());
            end
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("expected %p got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset)
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   stim_row_type table_rows[$];

   task automatic add_row(input logic [1:0] kind, input int src, input int dst,
                          input int wt, input int root, input logic typed,
                          input tree_row_type row);
      stim_row_type s;
      s = '{kind, src[4:0], dst[4:0], wt[15:0], root[4:0], typed, row};
      table_rows.push_back(s);
   endtask

   initial begin
      tree_row_type none;
      int phase_sel;
      none = '0;
      mismatches = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      edge_cnt = 0;
      ovf_flag = 1'b0;
      vcount = 32;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // run with no edges: root alone, everything else unreached
      add_row(KIND_RUN, 0, 0, 0, 31, 1'b0, none);
      add_row(KIND_ADD, 0, 31, -32768, 0, 1'b0, none);
      add_row(KIND_ADD, 31, 0, 32767, 0, 1'b0, none);
      add_row(KIND_ADD, 0, 1, 5, 0, 1'b0, none);
      add_row(KIND_ADD, 0, 2, 5, 0, 1'b0, none);
      add_row(KIND_ADD, 1, 2, 5, 0, 1'b0, none);
      add_row(KIND_ADD, 2, 1, 3, 0, 1'b0, none);
      add_row(KIND_ADD, 1, 1, -7, 0, 1'b0, none);
      add_row(KIND_SKIP, 31, 31, -1, 31, 1'b0, none);
      add_row(KIND_RUN, 0, 0, 0, 0, 1'b0, none);
      add_row(KIND_RUN, 0, 0, 0, 31, 1'b0, none);
      foreach (table_rows[i]) begin
         if (table_rows[i].kind == KIND_RUN) typed_flags.push_back(1'b0);
         send_request(table_rows[i].kind, table_rows[i].src, table_rows[i].dst,
                      table_rows[i].weight, table_rows[i].root);
      end
      typed_flags.delete();
      wait_idle();

      // bad roots at small counts (typed error result), a root-only run, count 63
      write_vertex_count(0);
      send_request(KIND_RUN, 0, 0, 0, 0);
      write_vertex_count(1);
      typed_rows.push_back('{5'd1, 5'd0, 1'b0, 16'sd0, 1'b0, 1'b1, 1'b1});
      typed_flags.push_back(1'b1);
      send_request(KIND_RUN, 0, 0, 0, 1);
      wait_idle();
      typed_flags.delete();
      typed_rows.delete();
      typed_rows.push_back('{5'd0, 5'd0, 1'b1, 16'sd0, 1'b0, 1'b0, 1'b1});
      typed_flags.push_back(1'b1);
      send_request(KIND_RUN, 0, 0, 0, 0);
      wait_idle();
      typed_flags.delete();
      typed_rows.delete();
      write_vertex_count(63);
      send_request(KIND_RUN, 0, 0, 0, 31);

      // fill the store past capacity
      write_vertex_count(8);
      for (int i = 0; i < MAX_EDGES + 3; i++)
         send_request(KIND_ADD, 5'($urandom_range(7)), 5'($urandom_range(7)),
                      16'($urandom), 5'($urandom));
      send_request(KIND_RUN, 0, 0, 0, 5'($urandom_range(7)));
      send_request(KIND_RUN, 0, 0, 0, 5'd9);

      // random phases
      for (int p = 0; p < 8; p++) begin
         phase_sel = p % 4;
         wait_idle();
         send_idle_pct = (phase_sel == 1 || phase_sel == 3) ? ((phase_sel == 1) ? 50 : 6) : 0;
         recv_stall_pct = (phase_sel == 2 || phase_sel == 3) ? ((phase_sel == 2) ? 50 : 6) : 0;
         write_vertex_count((p == 7) ? 32 : $urandom_range(2, 12));
         random_graph($urandom_range(6, 14), (vcount < 32) ? vcount + 1 : 32);
         for (int k = 0; k < 3; k++)
            send_request(KIND_RUN, 0, 0, 0,
                         ($urandom_range(4) == 0) ? 5'($urandom)
                                                  : 5'($urandom_range(vcount - 1)));
      end
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (tree_rows_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES / 100) @(posedge clock);
      if (mismatches == 0 && tree_rows_pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
